/* rtl/tsl_pkg.sv */
// Shared types and constants for the tick scheduled LED and button controller.
// No dependencies; used by every module under rtl/.
package tsl_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned TimeWidth = 32;

  // Register indexes on the configuration port
  localparam logic [AddrWidth-1:0] RegLedPeriod    = 3'd0;
  localparam logic [AddrWidth-1:0] RegPollPeriod   = 3'd1;
  localparam logic [AddrWidth-1:0] RegDebounceTime = 3'd2;
  localparam logic [AddrWidth-1:0] RegIntervalMin  = 3'd3;
  localparam logic [AddrWidth-1:0] RegIntervalMax  = 3'd4;
  localparam logic [AddrWidth-1:0] RegIntervalStep = 3'd5;

  // Reset values
  localparam logic [CfgWidth-1:0] LedPeriodRst    = 16'd500;
  localparam logic [CfgWidth-1:0] PollPeriodRst   = 16'd50;
  localparam logic [CfgWidth-1:0] DebounceTimeRst = 16'd100;
  localparam logic [CfgWidth-1:0] IntervalMinRst  = 16'd200;
  localparam logic [CfgWidth-1:0] IntervalMaxRst  = 16'd1000;
  localparam logic [CfgWidth-1:0] IntervalStepRst = 16'd100;
  localparam logic [CfgWidth-1:0] FlashIntervalRst = 16'd500;

  typedef struct packed {
    logic button_level;
    logic faster_level;
    logic slower_level;
  } in_t;

  typedef struct packed {
    logic led_level;
    logic flash_level;
  } out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] led_period;
    logic [CfgWidth-1:0] poll_period;
    logic [CfgWidth-1:0] debounce_time;
    logic [CfgWidth-1:0] interval_min;
    logic [CfgWidth-1:0] interval_max;
    logic [CfgWidth-1:0] interval_step;
  } cfg_t;

endpackage

/* rtl/tsl_cfg_regs.sv */
// Configuration register file: six 16-bit registers behind a plain write port.
// Depends on tsl_pkg.
module tsl_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsl_pkg::AddrWidth-1:0]    cfg_addr_i,
  input  logic [tsl_pkg::CfgWidth-1:0]     cfg_wdata_i,
  output tsl_pkg::cfg_t                    cfg_o
);

  tsl_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        tsl_pkg::RegLedPeriod:    cfg_d.led_period    = cfg_wdata_i;
        tsl_pkg::RegPollPeriod:   cfg_d.poll_period   = cfg_wdata_i;
        tsl_pkg::RegDebounceTime: cfg_d.debounce_time = cfg_wdata_i;
        tsl_pkg::RegIntervalMin:  cfg_d.interval_min  = cfg_wdata_i;
        tsl_pkg::RegIntervalMax:  cfg_d.interval_max  = cfg_wdata_i;
        tsl_pkg::RegIntervalStep: cfg_d.interval_step = cfg_wdata_i;
        default:                  cfg_d = cfg_q; // drop unknown index
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.led_period    <= tsl_pkg::LedPeriodRst;
      cfg_q.poll_period   <= tsl_pkg::PollPeriodRst;
      cfg_q.debounce_time <= tsl_pkg::DebounceTimeRst;
      cfg_q.interval_min  <= tsl_pkg::IntervalMinRst;
      cfg_q.interval_max  <= tsl_pkg::IntervalMaxRst;
      cfg_q.interval_step <= tsl_pkg::IntervalStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/tsl_tick_core.sv */
// Per-tick state and update logic: time base, LED, poll and flash counters,
// button debounce and flash interval stepping. Depends on tsl_pkg.
module tsl_tick_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  tsl_pkg::in_t   in_i,
  input  tsl_pkg::cfg_t  cfg_i,
  output tsl_pkg::out_t  res_o
);

  localparam int unsigned CW = tsl_pkg::CfgWidth;
  localparam int unsigned TW = tsl_pkg::TimeWidth;

  logic [TW-1:0] ms_q, ms_d, chg_q, chg_d, elapsed;
  logic [CW-1:0] led_cnt_q, led_cnt_d, poll_cnt_q, poll_cnt_d;
  logic [CW-1:0] flash_cnt_q, flash_cnt_d, ival_q, ival_d, ival_fast;
  logic [CW:0]   ival_sum;
  logic          toggle_q, toggle_d, led_q, led_d, flash_q, flash_d;
  logic          prev_btn_q, prev_btn_d, prev_fst_q, prev_fst_d, prev_slw_q, prev_slw_d;

  always_comb begin
    ms_d        = ms_q + 32'd1;
    led_cnt_d   = led_cnt_q - 16'd1;
    led_d       = led_q;
    poll_cnt_d  = poll_cnt_q - 16'd1;
    chg_d       = chg_q;
    toggle_d    = toggle_q;
    prev_btn_d  = prev_btn_q;
    flash_cnt_d = flash_cnt_q - 16'd1;
    flash_d     = flash_q;

    // LED counter expiry: copy the flag
    if (led_cnt_q == 16'd1) begin
      led_cnt_d = cfg_i.led_period;
      led_d     = toggle_q;
    end

    // Poll counter expiry: sample and debounce the main button
    if (poll_cnt_q == 16'd1) begin
      poll_cnt_d = cfg_i.poll_period;
      if (in_i.button_level != prev_btn_q) begin
        chg_d = ms_d;
      end
      prev_btn_d = in_i.button_level;
    end
    elapsed = ms_d - chg_d;
    if ((poll_cnt_q == 16'd1) && !in_i.button_level &&
        (elapsed > {16'h0, cfg_i.debounce_time})) begin
      toggle_d = ~toggle_q;
    end

    // Flash counter expiry: reload with half the interval
    if (flash_cnt_q == 16'd1) begin
      flash_cnt_d = ival_q >> 1;
      flash_d     = ~flash_q;
    end

    // Faster press first, then slower press on the updated interval
    ival_fast = ival_q;
    if (prev_fst_q && !in_i.faster_level && (ival_q > cfg_i.interval_min)) begin
      ival_fast = (ival_q >= cfg_i.interval_step) ? (ival_q - cfg_i.interval_step) : '0;
    end
    ival_sum = {1'b0, ival_fast} + {1'b0, cfg_i.interval_step};
    ival_d   = ival_fast;
    if (prev_slw_q && !in_i.slower_level && (ival_fast < cfg_i.interval_max)) begin
      ival_d = ival_sum[CW] ? '1 : ival_sum[CW-1:0];
    end
    prev_fst_d = in_i.faster_level;
    prev_slw_d = in_i.slower_level;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q        <= '0;
      chg_q       <= '0;
      led_cnt_q   <= tsl_pkg::LedPeriodRst;
      poll_cnt_q  <= tsl_pkg::PollPeriodRst;
      flash_cnt_q <= tsl_pkg::FlashIntervalRst;
      ival_q      <= tsl_pkg::FlashIntervalRst;
      toggle_q    <= 1'b0;
      led_q       <= 1'b0;
      flash_q     <= 1'b0;
      prev_btn_q  <= 1'b1;
      prev_fst_q  <= 1'b1;
      prev_slw_q  <= 1'b1;
    end else if (step_i) begin
      ms_q        <= ms_d;
      chg_q       <= chg_d;
      led_cnt_q   <= led_cnt_d;
      poll_cnt_q  <= poll_cnt_d;
      flash_cnt_q <= flash_cnt_d;
      ival_q      <= ival_d;
      toggle_q    <= toggle_d;
      led_q       <= led_d;
      flash_q     <= flash_d;
      prev_btn_q  <= prev_btn_d;
      prev_fst_q  <= prev_fst_d;
      prev_slw_q  <= prev_slw_d;
    end
  end

  assign res_o.led_level   = led_d;
  assign res_o.flash_level = flash_d;

endmodule

/* rtl/tick_scheduled_led_button_control_core.sv */
// An accepted item moves from the input register through one pass of tick logic into the result register.
// Throughput: one item per cycle while the result register is not stalled.
// A stalled result register holds one item and still lets one more wait in the input register.
// Reset (rst_ni low, asynchronous): both stages empty, registers and tick state at defaults.
// Depends on tsl_pkg, tsl_cfg_regs and tsl_tick_core.
module tick_scheduled_led_button_control_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items, one per 1 ms tick
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tsl_pkg::in_t                  in_data_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tsl_pkg::out_t                 out_data_o,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [tsl_pkg::AddrWidth-1:0] cfg_addr_i,
  input  logic [tsl_pkg::CfgWidth-1:0]  cfg_wdata_i
);

  tsl_pkg::cfg_t cfg;
  tsl_pkg::in_t  in_q;
  tsl_pkg::out_t res_d, out_q;
  logic          in_vld_q, out_vld_q;
  logic          adv;

  tsl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the held item into the result register when that register is
  // empty or is being emptied this cycle. The tick state moves in the same edge.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  tsl_tick_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .in_i   (in_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Input stage: hold the item until the tick logic takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result stage: hold the result until downstream takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // An advanced item always lands in the result register
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced item did not reach result register");

  // A waiting item is never dropped while the result side stalls
  a_stall_keeps_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_vld_q && !out_ready_i |=> in_vld_q)
    else $error("input item lost during output stall");

  // No result appears without an item behind it
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q && !out_vld_q |=> !out_vld_q)
    else $error("result appeared without an item");
`endif

endmodule

/* tb/sv/tsl_tick_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the tick scheduled LED and button controller: mirrors the per-tick
// counters, predicts the lamp levels of every tick item and checks each result item.
// Depends on tsl_pkg for the item, result and register types and the register indexes.
module tsl_tick_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  tsl_pkg::in_t                  in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  tsl_pkg::out_t                 out_data_i,
  input  logic                          cfg_we_i,
  input  logic [tsl_pkg::AddrWidth-1:0] cfg_addr_i,
  input  logic [tsl_pkg::CfgWidth-1:0]  cfg_wdata_i,
  output int unsigned                   pending_o,
  output int unsigned                   fail_count_o
);
  import tsl_pkg::*;

  cfg_t                 regs;
  logic [TimeWidth-1:0] tick_ms;
  logic [TimeWidth-1:0] stamp_ms;
  logic [CfgWidth-1:0]  led_left;
  logic [CfgWidth-1:0]  poll_left;
  logic [CfgWidth-1:0]  flash_left;
  logic [CfgWidth-1:0]  blink_interval;
  logic                 latch_flag;
  logic                 led_lit;
  logic                 blink_lit;
  logic                 button_last;
  logic                 faster_last;
  logic                 slower_last;
  out_t                 expected_lamps [$];
  int unsigned          results_seen;

  // One millisecond tick: LED copy, button poll, flash blink, then interval buttons.
  function automatic out_t advance_tick(in_t levels);
    logic [TimeWidth-1:0] held;
    logic [CfgWidth:0]    raised;
    out_t                 lamps;
    tick_ms = tick_ms + TimeWidth'(1);

    led_left = led_left - CfgWidth'(1);
    if (led_left == '0) begin
      led_left = regs.led_period;
      led_lit  = latch_flag;
    end

    poll_left = poll_left - CfgWidth'(1);
    if (poll_left == '0) begin
      poll_left = regs.poll_period;
      if (levels.button_level != button_last) stamp_ms = tick_ms;
      held = tick_ms - stamp_ms;
      if (held > TimeWidth'(regs.debounce_time) && !levels.button_level)
        latch_flag = ~latch_flag;
      button_last = levels.button_level;
    end

    flash_left = flash_left - CfgWidth'(1);
    if (flash_left == '0) begin
      flash_left = blink_interval >> 1;
      blink_lit  = ~blink_lit;
    end

    // Falling edges step the interval; clamp at zero and at full scale.
    if (faster_last && !levels.faster_level && blink_interval > regs.interval_min) begin
      blink_interval = (blink_interval >= regs.interval_step) ?
                       blink_interval - regs.interval_step : '0;
    end
    if (slower_last && !levels.slower_level && blink_interval < regs.interval_max) begin
      raised = {1'b0, blink_interval} + {1'b0, regs.interval_step};
      blink_interval = raised[CfgWidth] ? '1 : raised[CfgWidth-1:0];
    end
    faster_last = levels.faster_level;
    slower_last = levels.slower_level;

    lamps.led_level   = led_lit;
    lamps.flash_level = blink_lit;
    return lamps;
  endfunction

  task automatic flag_mismatch(string what);
    $display("[%0t] tick checker: %s", $time, what);
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_t want;
    if (!rst_ni) begin
      regs.led_period     = LedPeriodRst;
      regs.poll_period    = PollPeriodRst;
      regs.debounce_time  = DebounceTimeRst;
      regs.interval_min   = IntervalMinRst;
      regs.interval_max   = IntervalMaxRst;
      regs.interval_step  = IntervalStepRst;
      tick_ms        = '0;
      stamp_ms       = '0;
      led_left       = LedPeriodRst;
      poll_left      = PollPeriodRst;
      flash_left     = FlashIntervalRst;
      blink_interval = FlashIntervalRst;
      latch_flag     = 1'b0;
      led_lit        = 1'b0;
      blink_lit      = 1'b0;
      button_last    = 1'b1;
      faster_last    = 1'b1;
      slower_last    = 1'b1;
      expected_lamps.delete();
      results_seen   = 0;
      fail_count_o   = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (expected_lamps.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with no tick pending", results_seen));
        end else begin
          want = expected_lamps.pop_front();
          if (out_data_i.led_level !== want.led_level)
            flag_mismatch($sformatf("result %0d led_level got %b want %b", results_seen,
                                    out_data_i.led_level, want.led_level));
          if (out_data_i.flash_level !== want.flash_level)
            flag_mismatch($sformatf("result %0d flash_level got %b want %b", results_seen,
                                    out_data_i.flash_level, want.flash_level));
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          RegLedPeriod:    regs.led_period    = cfg_wdata_i;
          RegPollPeriod:   regs.poll_period   = cfg_wdata_i;
          RegDebounceTime: regs.debounce_time = cfg_wdata_i;
          RegIntervalMin:  regs.interval_min  = cfg_wdata_i;
          RegIntervalMax:  regs.interval_max  = cfg_wdata_i;
          RegIntervalStep: regs.interval_step = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_lamps.push_back(advance_tick(in_data_i));
    end
    pending_o = expected_lamps.size();
  end

endmodule

/* tb/sv/tb_tick_scheduled_led_button_control_core.sv */
`timescale 1ns / 100ps
// Testbench top for tick_scheduled_led_button_control_core: clock, reset, register
// phases and tick items with random gaps and stalls; gives the verdict.
// Depends on tsl_pkg, the block under test and tsl_tick_checker.
module tb_tick_scheduled_led_button_control_core;
  import tsl_pkg::*;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxWait      = 18;
  localparam int unsigned CalmEvery    = 40;

  // Indexes past the last register; writes there must change nothing.
  localparam logic [AddrWidth-1:0] RegSpareLo = 3'd6;
  localparam logic [AddrWidth-1:0] RegSpareHi = 3'd7;

  // Opening ticks as {button, faster, slower}, first item leftmost. Walks every level
  // combination and steps the interval from 500 down onto the reset floor of 200,
  // where a further faster press must be refused, then back up.
  localparam int unsigned OpeningCount = 21;
  localparam logic [3*OpeningCount-1:0] OpeningTicks = {
    3'b111, 3'b011, 3'b001, 3'b000, 3'b111, 3'b101, 3'b111, 3'b101, 3'b111, 3'b101,
    3'b111, 3'b101, 3'b110, 3'b111, 3'b110, 3'b100, 3'b010, 3'b000, 3'b001, 3'b110,
    3'b111
  };
  // Ticks 1..499 run on reset registers; the first write then lands just before
  // tick 500, where the LED, poll and flash counters all expire and reload together.
  localparam int unsigned ResetPhaseTicks = 499 - OpeningCount;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  in_t           in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  out_t          out_data_o;
  logic          cfg_we_i;
  logic [AddrWidth-1:0] cfg_addr_i;
  logic [CfgWidth-1:0]  cfg_wdata_i;

  int unsigned   pending_ticks;
  int unsigned   fail_count;
  int unsigned   cycle_count = 0;

  // Stimulus shaping state
  logic          button_hold = 1'b1;
  int unsigned   button_run_left = 0;
  int unsigned   faster_left = 0;
  int unsigned   slower_left = 0;
  int unsigned   ticks_sent = 0;
  bit            sender_calm = 1'b0;

  tick_scheduled_led_button_control_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  tsl_tick_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pending_o    (pending_ticks),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_tick_scheduled_led_button_control_core: FAIL");
      $finish;
    end
  end

  // Result side: stall a random number of cycles per item, then hold ready until the
  // item is taken. Every CalmEvery items, maybe switch to a stretch without stalls.
  // The handshake is judged at the falling edge, where valid and ready are settled.
  initial begin : result_sink
    int unsigned stall;
    int unsigned results_taken;
    bit          sink_calm;
    bit          got;
    results_taken = 0;
    sink_calm     = 1'b0;
    forever begin
      if (results_taken % CalmEvery == 0) sink_calm = ($urandom_range(0, 2) == 0);
      stall = sink_calm ? 0 : $urandom_range(0, MaxWait);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
      results_taken++;
    end
  end

  // Offer one tick item after a random gap; hold valid and payload until taken.
  task automatic send_tick(in_t levels);
    int unsigned gap;
    bit          taken;
    if (ticks_sent % CalmEvery == 0) sender_calm = ($urandom_range(0, 2) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, MaxWait);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= levels;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    ticks_sent++;
  endtask

  // Drop valid and hold off until every expected result is back, then let the
  // pipeline settle so no tick is still in flight.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_ticks != 0) @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(logic [AddrWidth-1:0] idx, logic [CfgWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  // Write all six registers while idle, plus junk to the unused indexes.
  task automatic load_regs(logic [CfgWidth-1:0] led, logic [CfgWidth-1:0] poll,
                           logic [CfgWidth-1:0] debounce, logic [CfgWidth-1:0] floor,
                           logic [CfgWidth-1:0] ceiling, logic [CfgWidth-1:0] step);
    wait_drained();
    put_reg(RegLedPeriod, led);
    put_reg(RegPollPeriod, poll);
    put_reg(RegDebounceTime, debounce);
    put_reg(RegIntervalMin, floor);
    put_reg(RegIntervalMax, ceiling);
    put_reg(RegIntervalStep, step);
    put_reg(RegSpareLo, CfgWidth'($urandom));
    put_reg(RegSpareHi, '0);
    cfg_we_i <= 1'b0;
  endtask

  // Main button: held levels in runs, mostly long and some short, with the odd
  // one-tick glitch. Faster and slower: short low pulses, so falling edges recur.
  function automatic in_t next_levels(int unsigned hold_max);
    in_t levels;
    if (button_run_left == 0) begin
      button_hold     = ~button_hold;
      button_run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                     : $urandom_range(8, hold_max);
    end
    button_run_left--;
    levels.button_level = ($urandom_range(0, 24) == 0) ? ~button_hold : button_hold;

    if (faster_left == 0 && $urandom_range(0, 7) == 0) faster_left = $urandom_range(1, 4);
    levels.faster_level = (faster_left == 0);
    if (faster_left != 0) faster_left--;

    if (slower_left == 0 && $urandom_range(0, 7) == 0) slower_left = $urandom_range(1, 4);
    levels.slower_level = (slower_left == 0);
    if (slower_left != 0) slower_left--;
    return levels;
  endfunction

  task automatic run_ticks(int unsigned count, int unsigned hold_max, bit pause_midway);
    for (int unsigned i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_drained();
      send_tick(next_levels(hold_max));
    end
  endtask

  initial begin : stimulus
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '1;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= RegLedPeriod;
    cfg_wdata_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening on reset registers.
    for (int unsigned i = 0; i < OpeningCount; i++)
      send_tick(in_t'(OpeningTicks[3*(OpeningCount-1-i) +: 3]));

    // Rest of the first 499 ticks on reset registers; long holds to pass 100 ms.
    run_ticks(ResetPhaseTicks, 300, 1'b0);

    // Low extremes: LED and poll every tick, no debounce, widest interval window.
    load_regs(16'd1, 16'd1, 16'd0, 16'd2, 16'hFFFF, 16'd1);
    run_ticks(100, 40, 1'b0);

    // Random small settings keep every counter busy; one phase pauses midway.
    for (int unsigned k = 0; k < 4; k++) begin
      load_regs(CfgWidth'($urandom_range(1, 9)), CfgWidth'($urandom_range(1, 6)),
                CfgWidth'($urandom_range(0, 25)), CfgWidth'($urandom_range(2, 40)),
                CfgWidth'($urandom_range(20, 120)), CfgWidth'($urandom_range(1, 30)));
      run_ticks(115, 60, k == 1);
    end

    // High extremes: debounce never met, interval window closed from both sides.
    load_regs(16'd3, 16'd2, 16'hFFFF, 16'hFFFF, 16'd2, 16'hFFFF);
    run_ticks(100, 40, 1'b0);

    // Zero LED period wraps its counter; full-scale step drives the interval
    // through underflow to zero, overflow to full scale, and a zero flash reload.
    load_regs(16'd0, 16'hFFFF, 16'd5, 16'd2, 16'hFFFF, 16'hFFFF);
    run_ticks(130, 40, 1'b0);

    // Remaining extremes: full-scale LED period, zero poll period.
    load_regs(16'hFFFF, 16'd0, 16'd0, 16'd2, 16'd1000, 16'd100);
    run_ticks(60, 40, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("tb_tick_scheduled_led_button_control_core: PASS");
    end else begin
      $display("tb_tick_scheduled_led_button_control_core: FAIL");
    end
    $finish;
  end

endmodule
